// ===== sv/psa_pkg.sv =====
`timescale 1ns / 1ps
package psa_pkg;
  localparam int unsigned DataW = 64;
  localparam int unsigned ModeW = 6;

  typedef enum logic [5:0] {
    M_ADDB = 6'd0, M_ADDW = 6'd1, M_ADDD = 6'd2,
    M_ADDSB = 6'd3, M_ADDSW = 6'd4, M_ADDUSB = 6'd5, M_ADDUSW = 6'd6,
    M_SUBB = 6'd7, M_SUBW = 6'd8, M_SUBD = 6'd9,
    M_SUBSB = 6'd10, M_SUBSW = 6'd11, M_SUBUSB = 6'd12, M_SUBUSW = 6'd13,
    M_MULHW = 6'd14, M_MULLW = 6'd15, M_MADDWD = 6'd16,
    M_EQB = 6'd17, M_EQW = 6'd18, M_EQD = 6'd19,
    M_GTB = 6'd20, M_GTW = 6'd21, M_GTD = 6'd22,
    M_SLLW = 6'd23, M_SLLD = 6'd24, M_SLLQ = 6'd25,
    M_SRLW = 6'd26, M_SRLD = 6'd27, M_SRLQ = 6'd28,
    M_SRAW = 6'd29, M_SRAD = 6'd30,
    M_AND = 6'd31, M_ANDN = 6'd32, M_OR = 6'd33, M_XOR = 6'd34,
    M_UNPLB = 6'd35, M_UNPLW = 6'd36, M_UNPLD = 6'd37,
    M_UNPHB = 6'd38, M_UNPHW = 6'd39, M_UNPHD = 6'd40,
    M_PACKSSWB = 6'd41, M_PACKSSDW = 6'd42, M_PACKUSWB = 6'd43,
    M_MOV = 6'd44
  } mode_t;

  // one 16-bit lane: all byte/word arithmetic, word multiply products
  typedef struct packed {
    logic [15:0] alu;
    logic [31:0] prod;
  } lane_res_t;
endpackage

// ===== sv/psa_if.sv =====
`timescale 1ns / 1ps
interface psa_in_if;
  logic        valid;
  logic        ready;
  logic [5:0]  mode;
  logic [63:0] first_operand;
  logic [63:0] second_operand;
  modport source (output valid, mode, first_operand, second_operand, input ready);
  modport sink (input valid, mode, first_operand, second_operand, output ready);
endinterface

interface psa_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result;
  logic        illegal;
  modport source (output valid, result, illegal, input ready);
  modport sink (input valid, result, illegal, output ready);
endinterface

// ===== sv/packed_simd_integer_alu.sv =====
`timescale 1ns / 1ps
// 64-bit packed integer ALU. One item per cycle unless the output stalls; the
// result is registered: four 16-bit lanes work in parallel and a merge stage
// forms the result, which is held in an output register; a new item is taken
// whenever that register is empty or being drained. Mode codes 45..63 set illegal and return the first
// operand unchanged. Shift counts come from the low byte of the second operand.
module packed_simd_integer_alu import psa_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  psa_in_if.sink    in_ch,
  psa_out_if.source out_ch
);
  lane_res_t lr [4];
  logic [63:0] res;
  logic ill;
  logic valid_r;
  logic [63:0] result_r;
  logic illegal_r;

  for (genvar i = 0; i < 4; i++) begin : g_lane
    psa_lane u_lane (
      .mode(in_ch.mode),
      .a(in_ch.first_operand[16*i +: 16]),
      .b(in_ch.second_operand[16*i +: 16]),
      .cnt(in_ch.second_operand[7:0]),
      .res(lr[i])
    );
  end

  psa_merge u_merge (
    .mode(in_ch.mode), .a(in_ch.first_operand), .b(in_ch.second_operand),
    .lr(lr), .result(res), .illegal(ill)
  );

  assign in_ch.ready = !valid_r || out_ch.ready;
  assign out_ch.valid = valid_r;
  assign out_ch.result = result_r;
  assign out_ch.illegal = illegal_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      result_r <= res;
      illegal_r <= ill;
    end
  end
endmodule

// ===== sv/psa_lane.sv =====
`timescale 1ns / 1ps
// one 16-bit lane: byte ops on its two halves, word ops, signed product
module psa_lane import psa_pkg::*; (
  input  logic [5:0]  mode,
  input  logic [15:0] a,
  input  logic [15:0] b,
  input  logic [7:0]  cnt,
  output lane_res_t   res
);
  function automatic logic [7:0] bop(input logic [5:0] m, input logic [7:0] x,
                                     input logic [7:0] y);
    logic [8:0] s, d;
    logic signed [8:0] ss, sd;
    logic [7:0] r;
    s = {1'b0, x} + {1'b0, y};
    d = {1'b0, x} - {1'b0, y};
    ss = $signed({x[7], x}) + $signed({y[7], y});
    sd = $signed({x[7], x}) - $signed({y[7], y});
    case (m)
      M_ADDB: r = s[7:0];
      M_ADDSB: r = (ss > 9'sd127) ? 8'h7F : (ss < -9'sd128) ? 8'h80 : ss[7:0];
      M_ADDUSB: r = s[8] ? 8'hFF : s[7:0];
      M_SUBB: r = d[7:0];
      M_SUBSB: r = (sd > 9'sd127) ? 8'h7F : (sd < -9'sd128) ? 8'h80 : sd[7:0];
      M_SUBUSB: r = d[8] ? 8'h00 : d[7:0];
      M_EQB: r = (x == y) ? 8'hFF : 8'h00;
      M_GTB: r = ($signed(x) > $signed(y)) ? 8'hFF : 8'h00;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  logic [16:0] s, d;
  logic signed [16:0] ss, sd;
  logic [15:0] w;
  logic [3:0] sc;
  logic big;

  always_comb begin
    s = {1'b0, a} + {1'b0, b};
    d = {1'b0, a} - {1'b0, b};
    ss = $signed({a[15], a}) + $signed({b[15], b});
    sd = $signed({a[15], a}) - $signed({b[15], b});
    big = (cnt >= 8'd16);
    sc = big ? 4'd15 : cnt[3:0];
    case (mode)
      M_ADDW: w = s[15:0];
      M_ADDSW: w = (ss > 17'sd32767) ? 16'h7FFF : (ss < -17'sd32768) ? 16'h8000 : ss[15:0];
      M_ADDUSW: w = s[16] ? 16'hFFFF : s[15:0];
      M_SUBW: w = d[15:0];
      M_SUBSW: w = (sd > 17'sd32767) ? 16'h7FFF : (sd < -17'sd32768) ? 16'h8000 : sd[15:0];
      M_SUBUSW: w = d[16] ? 16'h0000 : d[15:0];
      M_EQW: w = (a == b) ? 16'hFFFF : 16'h0000;
      M_GTW: w = ($signed(a) > $signed(b)) ? 16'hFFFF : 16'h0000;
      M_SLLW: w = big ? 16'h0000 : (a << cnt[3:0]);
      M_SRLW: w = big ? 16'h0000 : (a >> cnt[3:0]);
      M_SRAW: w = 16'($signed(a) >>> sc);
      default: w = {bop(mode, a[15:8], b[15:8]), bop(mode, a[7:0], b[7:0])};
    endcase
    res.alu = w;
    res.prod = 32'($signed(a) * $signed(b));
  end
endmodule

// ===== sv/psa_merge.sv =====
`timescale 1ns / 1ps
// combines lane results and handles dword/qword and reordering ops
module psa_merge import psa_pkg::*; (
  input  logic [5:0]  mode,
  input  logic [63:0] a,
  input  logic [63:0] b,
  input  lane_res_t   lr [4],
  output logic [63:0] result,
  output logic        illegal
);
  function automatic logic [7:0] sat_sb(input logic [15:0] v);
    if ($signed(v) > 16'sd127) return 8'h7F;
    if ($signed(v) < -16'sd128) return 8'h80;
    return v[7:0];
  endfunction
  function automatic logic [7:0] sat_ub(input logic [15:0] v);
    if (v[15]) return 8'h00;
    if (v > 16'd255) return 8'hFF;
    return v[7:0];
  endfunction
  function automatic logic [15:0] sat_sw(input logic [31:0] v);
    if ($signed(v) > 32'sd32767) return 16'h7FFF;
    if ($signed(v) < -32'sd32768) return 16'h8000;
    return v[15:0];
  endfunction

  logic [63:0] lanes, mulh, mull, madd, dw, q;
  logic [7:0]  cnt;
  logic [4:0]  dsc;

  always_comb begin
    cnt = b[7:0];
    dsc = (cnt >= 8'd32) ? 5'd31 : cnt[4:0];
    for (int i = 0; i < 4; i++) begin
      lanes[16*i +: 16] = lr[i].alu;
      mulh[16*i +: 16] = lr[i].prod[31:16];
      mull[16*i +: 16] = lr[i].prod[15:0];
    end
    for (int i = 0; i < 2; i++) begin
      madd[32*i +: 32] = lr[2*i].prod + lr[2*i+1].prod;
    end
    for (int i = 0; i < 2; i++) begin
      case (mode)
        M_ADDD: dw[32*i +: 32] = a[32*i +: 32] + b[32*i +: 32];
        M_SUBD: dw[32*i +: 32] = a[32*i +: 32] - b[32*i +: 32];
        M_EQD: dw[32*i +: 32] = (a[32*i +: 32] == b[32*i +: 32]) ? '1 : '0;
        M_GTD: dw[32*i +: 32] =
          ($signed(a[32*i +: 32]) > $signed(b[32*i +: 32])) ? '1 : '0;
        M_SLLD: dw[32*i +: 32] = (cnt >= 8'd32) ? '0 : (a[32*i +: 32] << cnt[4:0]);
        M_SRLD: dw[32*i +: 32] = (cnt >= 8'd32) ? '0 : (a[32*i +: 32] >> cnt[4:0]);
        default: dw[32*i +: 32] = 32'($signed(a[32*i +: 32]) >>> dsc);
      endcase
    end
    q = '0;
    illegal = 1'b0;
    case (mode)
      M_ADDD, M_SUBD, M_EQD, M_GTD, M_SLLD, M_SRLD, M_SRAD: q = dw;
      M_MULHW: q = mulh;
      M_MULLW: q = mull;
      M_MADDWD: q = madd;
      M_SLLQ: q = (cnt >= 8'd64) ? '0 : (a << cnt[5:0]);
      M_SRLQ: q = (cnt >= 8'd64) ? '0 : (a >> cnt[5:0]);
      M_AND: q = a & b;
      M_ANDN: q = ~a & b;
      M_OR: q = a | b;
      M_XOR: q = a ^ b;
      M_UNPLB, M_UNPHB: begin
        for (int k = 0; k < 4; k++) begin
          q[16*k +: 8] = a[8*(k + ((mode == M_UNPHB) ? 4 : 0)) +: 8];
          q[16*k+8 +: 8] = b[8*(k + ((mode == M_UNPHB) ? 4 : 0)) +: 8];
        end
      end
      M_UNPLW: q = {b[31:16], a[31:16], b[15:0], a[15:0]};
      M_UNPHW: q = {b[63:48], a[63:48], b[47:32], a[47:32]};
      M_UNPLD: q = {b[31:0], a[31:0]};
      M_UNPHD: q = {b[63:32], a[63:32]};
      M_PACKSSWB, M_PACKUSWB: begin
        for (int i = 0; i < 4; i++) begin
          q[8*i +: 8] = (mode == M_PACKUSWB) ? sat_ub(a[16*i +: 16]) : sat_sb(a[16*i +: 16]);
          q[8*(i+4) +: 8] =
            (mode == M_PACKUSWB) ? sat_ub(b[16*i +: 16]) : sat_sb(b[16*i +: 16]);
        end
      end
      M_PACKSSDW: q = {sat_sw(b[63:32]), sat_sw(b[31:0]), sat_sw(a[63:32]), sat_sw(a[31:0])};
      M_MOV: q = b;
      default: begin
        if (mode <= M_SRAD) begin
          q = lanes;
        end else begin
          q = a;
          illegal = 1'b1;
        end
      end
    endcase
    result = q;
  end
endmodule

// ===== sv/psa_checker.sv =====
`timescale 1ns / 1ps
module psa_checker import psa_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic [5:0] in_mode,
  input logic [63:0] in_a,
  input logic [63:0] in_b,
  input logic out_valid,
  input logic out_ready,
  input logic [63:0] out_result,
  input logic out_illegal
);
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result))
    else $error("result changed under stall");
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted item not presented");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked while empty");
  a_illegal: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_mode > M_MOV |=> out_illegal && out_result == $past(in_a))
    else $error("illegal mode not passed through");
  a_mov: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_mode == M_MOV |=> !out_illegal && out_result == $past(in_b))
    else $error("copy mismatch");
endmodule

bind packed_simd_integer_alu psa_checker u_psa_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_mode(in_ch.mode),
  .in_a(in_ch.first_operand), .in_b(in_ch.second_operand),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_result(out_ch.result), .out_illegal(out_ch.illegal)
);

// ===== bench/tb_packed_simd_integer_alu.sv =====
`timescale 1ns / 1ps
module tb_packed_simd_integer_alu;
  import psa_pkg::*;

  typedef struct {
    logic [63:0] result;
    logic        illegal;
  } alu_out_t;

  int unsigned err_count = 0;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    err_count++;
  endtask

  // lane helpers
  function automatic logic [63:0] lane_mask(int w);
    return (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
  endfunction

  function automatic longint sx(logic [63:0] v, int w);
    logic [63:0] m;
    m = v & lane_mask(w);
    if (m[w-1]) return longint'(m) - (longint'(1) << w);
    return longint'(m);
  endfunction

  function automatic logic [63:0] sat_s(longint v, int w);
    longint hi;
    longint lo;
    hi = (longint'(1) << (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return logic'(v) ? (64'(v) & lane_mask(w)) : (64'(v) & lane_mask(w));
  endfunction

  function automatic logic [63:0] sat_u(longint v, int w);
    longint hi;
    hi = (longint'(1) << w) - 1;
    if (v > hi) v = hi;
    if (v < 0) v = 0;
    return 64'(v);
  endfunction

  function automatic logic [63:0] lanewise(mode_t md, logic [63:0] a, logic [63:0] b);
    int w;
    int cnt;
    logic [63:0] m;
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] r;
    logic [63:0] v;
    logic [127:0] wide;
    case (md)
      M_ADDB, M_ADDSB, M_ADDUSB, M_SUBB, M_SUBSB, M_SUBUSB, M_EQB, M_GTB: w = 8;
      M_ADDD, M_SUBD, M_EQD, M_GTD, M_SLLD, M_SRLD, M_SRAD: w = 32;
      M_SLLQ, M_SRLQ: w = 64;
      default: w = 16;
    endcase
    m = lane_mask(w);
    cnt = b[7:0];
    r = '0;
    for (int i = 0; i < 64 / w; i++) begin
      x = (a >> (i * w)) & m;
      y = (b >> (i * w)) & m;
      case (md)
        M_ADDB, M_ADDW, M_ADDD: v = x + y;
        M_ADDSB, M_ADDSW: v = sat_s(sx(x, w) + sx(y, w), w);
        M_ADDUSB, M_ADDUSW: v = (x + y > m) ? m : x + y;
        M_SUBB, M_SUBW, M_SUBD: v = x - y;
        M_SUBSB, M_SUBSW: v = sat_s(sx(x, w) - sx(y, w), w);
        M_SUBUSB, M_SUBUSW: v = (x < y) ? 64'd0 : x - y;
        M_MULHW: v = 64'(sx(x, w) * sx(y, w)) >> 16;
        M_MULLW: v = x * y;
        M_EQB, M_EQW, M_EQD: v = (x == y) ? m : 64'd0;
        M_GTB, M_GTW, M_GTD: v = (sx(x, w) > sx(y, w)) ? m : 64'd0;
        M_SLLW, M_SLLD, M_SLLQ: v = (cnt >= w) ? 64'd0 : x << cnt;
        M_SRLW, M_SRLD, M_SRLQ: v = (cnt >= w) ? 64'd0 : x >> cnt;
        default: begin
          // arithmetic: oversize count fills with sign
          wide = {64'(sx(x, w) < 0 ? -1 : 0), x};
          v = 64'(wide >> ((cnt >= w) ? w - 1 : cnt));
          v = v | (x[w-1] ? ~(m >> ((cnt >= w) ? w - 1 : cnt)) : 64'd0);
        end
      endcase
      r |= (v & m) << (i * w);
    end
    return r;
  endfunction

  function automatic logic [63:0] interleave(logic [63:0] a, logic [63:0] b, int w, bit hi);
    int half;
    logic [63:0] r;
    half = 32 / w;
    r = '0;
    for (int k = 0; k < half; k++) begin
      r |= ((a >> ((k + (hi ? half : 0)) * w)) & lane_mask(w)) << (2 * k * w);
      r |= ((b >> ((k + (hi ? half : 0)) * w)) & lane_mask(w)) << ((2 * k + 1) * w);
    end
    return r;
  endfunction

  function automatic logic [63:0] narrow(logic [63:0] a, logic [63:0] b, int w, bit uns);
    int n;
    int h;
    longint va;
    longint vb;
    logic [63:0] r;
    n = 64 / w;
    h = w / 2;
    r = '0;
    for (int i = 0; i < n; i++) begin
      va = sx(a >> (i * w), w);
      vb = sx(b >> (i * w), w);
      r |= ((uns ? sat_u(va, h) : sat_s(va, h)) & lane_mask(h)) << (i * h);
      r |= ((uns ? sat_u(vb, h) : sat_s(vb, h)) & lane_mask(h)) << ((i + n) * h);
    end
    return r;
  endfunction

  function automatic alu_out_t alu_predict(logic [5:0] code, logic [63:0] a, logic [63:0] b);
    alu_out_t o;
    longint p0;
    longint p1;
    o.illegal = 1'b0;
    if (code <= M_SRAD && code != M_MADDWD) begin
      o.result = lanewise(mode_t'(code), a, b);
    end else begin
      case (code)
        M_MADDWD: begin
          o.result = '0;
          for (int i = 0; i < 2; i++) begin
            p0 = sx(a >> (32 * i), 16) * sx(b >> (32 * i), 16);
            p1 = sx(a >> (32 * i + 16), 16) * sx(b >> (32 * i + 16), 16);
            o.result |= (64'(p0 + p1) & 64'hFFFF_FFFF) << (32 * i);
          end
        end
        M_AND: o.result = a & b;
        M_ANDN: o.result = ~a & b;
        M_OR: o.result = a | b;
        M_XOR: o.result = a ^ b;
        M_UNPLB: o.result = interleave(a, b, 8, 0);
        M_UNPLW: o.result = interleave(a, b, 16, 0);
        M_UNPLD: o.result = interleave(a, b, 32, 0);
        M_UNPHB: o.result = interleave(a, b, 8, 1);
        M_UNPHW: o.result = interleave(a, b, 16, 1);
        M_UNPHD: o.result = interleave(a, b, 32, 1);
        M_PACKSSWB: o.result = narrow(a, b, 16, 0);
        M_PACKSSDW: o.result = narrow(a, b, 32, 0);
        M_PACKUSWB: o.result = narrow(a, b, 16, 1);
        M_MOV: o.result = b;
        default: begin
          o.result = a;
          o.illegal = 1'b1;
        end
      endcase
    end
    return o;
  endfunction

  class alu_scoreboard;
    alu_out_t pending[$];
    int unsigned checked = 0;

    function void note_item(logic [5:0] code, logic [63:0] a, logic [63:0] b);
      pending.push_back(alu_predict(code, a, b));
    endfunction

    task check_result(logic [63:0] res, logic ill);
      alu_out_t e;
      if (pending.size() == 0) begin
        report("unexpected result", res, 64'd0);
        return;
      end
      e = pending.pop_front();
      checked++;
      if (res !== e.result) report("result", res, e.result);
      if (ill !== e.illegal) report("illegal", 64'(ill), 64'(e.illegal));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  psa_in_if in_ch ();
  psa_out_if out_ch ();
  alu_scoreboard sb = new();
  int unsigned cycle = 0;
  int unsigned sent = 0;
  bit stim_done = 0;
  bit [44:0] modes_seen = '0;
  localparam int unsigned CycleLimit = 200000;

  packed_simd_integer_alu u_top (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  always #10 clk = ~clk;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  function automatic logic [63:0] rand_operand();
    logic [63:0] v;
    int k;
    v = {$urandom, $urandom};
    k = $urandom_range(0, 9);
    case (k)
      0: v = '0;
      1: v = '1;
      2: v = {4{16'h8000}};
      3: v = {4{16'h7FFF}};
      4: v = {8{8'h80}};
      5: v = {8{8'h7F}};
      default: ;
    endcase
    return v;
  endfunction

  // called at a falling edge; valid stays high across back to back items
  task automatic send_item(logic [5:0] code, logic [63:0] a, logic [63:0] b);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= code;
    in_ch.first_operand <= a;
    in_ch.second_operand <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_item(code, a, b);
    if (code <= M_MOV) modes_seen[code] = 1'b1;
    sent++;
    @(negedge clk);
  endtask

  // sink side: random stalls on ready
  always @(negedge clk) begin
    if (rst_n) out_ch.ready <= (gap_len() == 0) || ($urandom_range(0, 3) == 0);
  end

  always @(posedge clk) begin
    cycle++;
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.result, out_ch.illegal);
    if (cycle > CycleLimit) begin
      $display("timeout after %0d cycles", cycle);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    logic [63:0] b;
    in_ch.valid = 1'b0;
    in_ch.mode = '0;
    in_ch.first_operand = '0;
    in_ch.second_operand = '0;
    out_ch.ready = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // directed corners
    send_item(M_ADDSB, {8{8'h7F}}, {8{8'h01}});
    send_item(M_SUBSW, {4{16'h8000}}, {4{16'h0001}});
    send_item(M_ADDUSW, '1, '1);
    send_item(M_SUBUSB, '0, '1);
    send_item(M_MULHW, {4{16'h8000}}, {4{16'h8000}});
    send_item(M_MADDWD, {4{16'h8000}}, {4{16'h8000}});
    send_item(M_SLLW, '1, 64'd16);
    send_item(M_SRLQ, '1, 64'd64);
    send_item(M_SRAW, {4{16'h8001}}, 64'd200);
    send_item(M_SRAD, {2{32'h7000_0001}}, 64'd255);
    send_item(M_SLLQ, 64'h1, 64'd63);
    send_item(M_EQB, 64'h00FF_00FF_1234_5678, 64'h00FF_FF00_1234_0078);
    send_item(M_GTD, 64'h8000_0000_7FFF_FFFF, 64'h7FFF_FFFF_8000_0000);
    send_item(M_PACKSSWB, 64'h7FFF_8000_0080_FF7F, 64'h0001_FFFF_FF80_0000);
    send_item(M_PACKSSDW, 64'h0001_0000_FFFF_0000, 64'h0000_7FFF_8000_0000);
    send_item(M_PACKUSWB, 64'h0100_FFFF_00FF_0080, 64'h8000_7FFF_0001_0000);
    send_item(6'd45, 64'hDEAD_BEEF_0123_4567, '1);
    send_item(6'd63, '1, '0);
    for (int m = 0; m <= 44; m++) send_item(m[5:0], rand_operand(), rand_operand());
    // random part
    for (int n = 0; n < 600; n++) begin
      b = rand_operand();
      // for half the items the count byte is drawn from 0..70, around the lane widths
      if ($urandom_range(0, 1)) b[7:0] = $urandom_range(0, 70);
      send_item(($urandom_range(0, 9) == 0) ? 6'($urandom_range(45, 63))
                                            : 6'($urandom_range(0, 44)), rand_operand(), b);
    end
    in_ch.valid <= 1'b0;
    stim_done = 1;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("sent %0d items, checked %0d results", sent, sb.checked);
    $display("modes exercised: %0d of 45 plus illegal codes", $countones(modes_seen));
    if (err_count == 0 && sb.pending.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
